>>> rtl/core/ppi_pkg.sv
// Shared types and constants for the mode 0 parallel port interface.
// Used by ppi_exec, parallel_port_interface_mode0 and the testbench; no dependencies.

package ppi_pkg;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    localparam logic [1:0] ADDR_PORT_A  = 2'd0;
    localparam logic [1:0] ADDR_PORT_B  = 2'd1;
    localparam logic [1:0] ADDR_PORT_C  = 2'd2;
    localparam logic [1:0] ADDR_CONTROL = 2'd3;

    localparam logic [7:0] CW_MODE_SET  = 8'h80;
    localparam logic [7:0] CW_A_MODE    = 8'h60;
    localparam logic [7:0] CW_A_INPUT   = 8'h10;
    localparam logic [7:0] CW_CU_INPUT  = 8'h08;
    localparam logic [7:0] CW_B_MODE    = 8'h04;
    localparam logic [7:0] CW_B_INPUT   = 8'h02;
    localparam logic [7:0] CW_CL_INPUT  = 8'h01;
    localparam logic [7:0] C_UPPER_MASK = 8'hF0;
    localparam logic [7:0] C_LOWER_MASK = 8'h0F;

    typedef struct packed {
        logic [7:0] latch_a;
        logic [7:0] latch_b;
        logic [7:0] latch_c;
        logic [7:0] control_word;
    } ppi_state_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] reg_address;
        logic [7:0] write_data;
        logic [7:0] pins_a;
        logic [7:0] pins_b;
        logic [7:0] pins_c;
    } ppi_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] drive_a;
        logic [7:0] drive_b;
        logic [7:0] drive_c;
        logic [3:0] drive_mask;
        logic       status;
    } ppi_result_t;

endpackage

>>> rtl/core/ppi_exec.sv
// Combinational execution of one word: next register state and result.
// Depends on ppi_pkg.

module ppi_exec
    import ppi_pkg::*;
(
    input  ppi_item_t   item,
    input  ppi_state_t  state,
    output ppi_state_t  state_next,
    output ppi_result_t result
);

    logic [7:0] cw;
    logic [7:0] dcw;
    logic [1:0] mode_a;
    logic [1:0] dmode_a;
    logic [7:0] bit_mask;
    logic [7:0] bsr_value;
    logic [7:0] c_write;
    logic [7:0] c_pins;
    logic       status_w;

    always_comb
    begin
        cw        = state.control_word;
        dcw       = item.write_data;
        mode_a    = cw[6:5];
        dmode_a   = dcw[6:5];
        bit_mask  = 8'h01 << item.write_data[3:1];
        bsr_value = item.write_data[0] ? (state.latch_c | bit_mask)
                                       : (state.latch_c & ~bit_mask);
        c_write   = (item.reg_address == ADDR_PORT_C) ? item.write_data : bsr_value;
        c_pins    = item.pins_c;

        state_next = state;
        status_w   = 1'b0;
        result.read_data = 8'h00;

        unique case (item.operation)
            OP_READ:
            begin
                unique case (item.reg_address)
                    ADDR_PORT_A:  result.read_data = state.latch_a;
                    ADDR_PORT_B:  result.read_data = state.latch_b;
                    ADDR_PORT_C:  result.read_data = state.latch_c;
                    default:      result.read_data = state.control_word;
                endcase
            end
            OP_WRITE:
            begin
                if (item.reg_address == ADDR_PORT_A)
                begin
                    if ((cw & CW_A_MODE) != 8'h00)
                        status_w = 1'b1;
                    else if ((cw & CW_A_INPUT) == 8'h00)
                        state_next.latch_a = item.write_data;
                end
                else if (item.reg_address == ADDR_PORT_B)
                begin
                    if ((cw & CW_B_INPUT) == 8'h00)
                        state_next.latch_b = item.write_data;
                end
                else if (item.reg_address == ADDR_CONTROL && (dcw & CW_MODE_SET) != 8'h00)
                begin
                    state_next.control_word = dcw;
                    state_next.latch_a = ((dcw & CW_A_INPUT) != 8'h00 && dmode_a == 2'd0)
                                         ? item.pins_a : 8'h00;
                    status_w = ((dcw & CW_A_INPUT) != 8'h00) && dmode_a[1];
                    state_next.latch_b = ((dcw & CW_B_MODE) == 8'h00
                                          && (dcw & CW_B_INPUT) != 8'h00)
                                         ? item.pins_b : 8'h00;
                    state_next.latch_c =
                        (((dcw & CW_CU_INPUT) != 8'h00) ? (c_pins & C_UPPER_MASK) : 8'h00) |
                        (((dcw & CW_CL_INPUT) != 8'h00) ? (c_pins & C_LOWER_MASK) : 8'h00);
                end
                else
                begin
                    state_next.latch_c =
                        (((cw & CW_CU_INPUT) == 8'h00) ? c_write : state.latch_c) & C_UPPER_MASK |
                        (((cw & CW_CL_INPUT) == 8'h00) ? c_write : state.latch_c) & C_LOWER_MASK;
                end
            end
            OP_SAMPLE:
            begin
                status_w = mode_a[1];
                if (mode_a == 2'd0 && (cw & CW_A_INPUT) != 8'h00)
                    state_next.latch_a = item.pins_a;
                if ((cw & CW_B_MODE) == 8'h00 && (cw & CW_B_INPUT) != 8'h00)
                    state_next.latch_b = item.pins_b;
                state_next.latch_c =
                    (((cw & CW_CU_INPUT) != 8'h00) ? c_pins : state.latch_c) & C_UPPER_MASK |
                    (((cw & CW_CL_INPUT) != 8'h00) ? c_pins : state.latch_c) & C_LOWER_MASK;
            end
            default:
            begin
                status_w = 1'b0;
            end
        endcase

        result.drive_a    = state_next.latch_a;
        result.drive_b    = state_next.latch_b;
        result.drive_c    = state_next.latch_c;
        result.drive_mask = {(state_next.control_word & CW_CL_INPUT) == 8'h00,
                             (state_next.control_word & CW_CU_INPUT) == 8'h00,
                             (state_next.control_word & CW_B_INPUT)  == 8'h00,
                             (state_next.control_word & CW_A_INPUT)  == 8'h00};
        result.status     = status_w;
    end

endmodule

>>> rtl/core/parallel_port_interface_mode0.sv
// Top level of the mode 0 parallel port interface: input register, port
// latches and control word, result register. Depends on ppi_pkg and ppi_exec.
//
// Usage:
// Each input word is a bus read, a bus write or a sample of the A, B and C
// pins, and yields exactly one result word carrying the read data, the
// three port latches, the output enables and an error status.
// Both channels use valid and stall; a word moves at a rising edge where
// valid is high and stall is low.
// A word taken at an edge is registered, executed against the port state,
// and its result is registered in the result register. Throughput is one
// word per cycle while the receiver does not stall, set by the single pass
// through the execute logic between the input and result registers.
// When the receiver stalls, the result register holds its word; the input
// register then also holds, and in_stall rises while it is occupied.
// Reset empties both pipeline stages and clears all port latches and the
// control word, leaving every port an output in mode 0 with a zero latch.

module parallel_port_interface_mode0
    import ppi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [1:0] reg_address,
    input  logic [7:0] write_data,
    input  logic [7:0] pins_a,
    input  logic [7:0] pins_b,
    input  logic [7:0] pins_c,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic [7:0] drive_a,
    output logic [7:0] drive_b,
    output logic [7:0] drive_c,
    output logic [3:0] drive_mask,
    output logic       status
);

    logic        item_valid_reg;
    ppi_item_t   item_reg;
    ppi_state_t  state_reg;
    ppi_state_t  state_next;
    logic        out_valid_reg;
    ppi_result_t result_reg;
    ppi_result_t result_next;
    logic        advance;

    ppi_exec u_exec
    (
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (!in_stall)
                item_valid_reg <= in_valid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= '{operation, reg_address, write_data, pins_a, pins_b, pins_c};
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = result_reg.read_data;
    assign drive_a    = result_reg.drive_a;
    assign drive_b    = result_reg.drive_b;
    assign drive_c    = result_reg.drive_c;
    assign drive_mask = result_reg.drive_mask;
    assign status     = result_reg.status;

`ifndef ASSERT_OFF
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg)
        else $error("in_stall raised with an empty input register");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("executed word did not reach the result register");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !item_valid_reg) |=> !out_valid)
        else $error("result word repeated after it was taken");
`endif

endmodule

>>> tb/ppi_word_checker.sv
// Checker for the mode 0 parallel port interface: watches both channels, predicts each
// result word from its own copy of the port latches and control word, and counts mismatches.
// Depends on ppi_pkg for the word layouts, operation codes and control word bits.

module ppi_word_checker
    import ppi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] operation,
    input  logic [1:0] reg_address,
    input  logic [7:0] write_data,
    input  logic [7:0] pins_a,
    input  logic [7:0] pins_b,
    input  logic [7:0] pins_c,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] read_data,
    input  logic [7:0] drive_a,
    input  logic [7:0] drive_b,
    input  logic [7:0] drive_c,
    input  logic [3:0] drive_mask,
    input  logic       status,
    output int         fail_count,
    output int         words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] A_MODE_BASIC = 2'd0;
    localparam logic [1:0] A_MODE_BIDIR = 2'd2;
    localparam logic       STATUS_OK         = 1'b0;
    localparam logic       STATUS_A_MODE_ERR = 1'b1;

    ppi_state_t  port_state;
    ppi_result_t expected_words[$];

    function automatic void load_port_c(input logic [7:0] value);
        if ((port_state.control_word & CW_CU_INPUT) == '0)
            port_state.latch_c = (port_state.latch_c & C_LOWER_MASK) | (value & C_UPPER_MASK);
        if ((port_state.control_word & CW_CL_INPUT) == '0)
            port_state.latch_c = (port_state.latch_c & C_UPPER_MASK) | (value & C_LOWER_MASK);
    endfunction

    function automatic logic take_port_pins(input logic [7:0] pa, input logic [7:0] pb,
                                            input logic [7:0] pc, input logic a_only_if_input);
        logic [7:0] cw;
        logic [1:0] mode_a;
        logic       a_in;
        logic       err;
        cw = port_state.control_word;
        mode_a = cw[6:5];
        a_in = (cw & CW_A_INPUT) != '0;
        err = STATUS_OK;
        if (a_in || !a_only_if_input)
        begin
            if (mode_a == A_MODE_BASIC)
            begin
                if (a_in)
                    port_state.latch_a = pa;
            end
            else if (mode_a >= A_MODE_BIDIR)
                err = STATUS_A_MODE_ERR;
        end
        if ((cw & CW_B_MODE) == '0 && (cw & CW_B_INPUT) != '0)
            port_state.latch_b = pb;
        if ((cw & CW_CU_INPUT) != '0)
            port_state.latch_c = (port_state.latch_c & C_LOWER_MASK) | (pc & C_UPPER_MASK);
        if ((cw & CW_CL_INPUT) != '0)
            port_state.latch_c = (port_state.latch_c & C_UPPER_MASK) | (pc & C_LOWER_MASK);
        return err;
    endfunction

    function automatic ppi_result_t apply_port_word(input ppi_item_t w);
        ppi_result_t r;
        logic [7:0]  bit_sel;
        logic [7:0]  c_value;
        r = '0;
        case (w.operation)
            OP_READ:
                case (w.reg_address)
                    ADDR_PORT_A: r.read_data = port_state.latch_a;
                    ADDR_PORT_B: r.read_data = port_state.latch_b;
                    ADDR_PORT_C: r.read_data = port_state.latch_c;
                    default:     r.read_data = port_state.control_word;
                endcase
            OP_WRITE:
                case (w.reg_address)
                    ADDR_PORT_A:
                        if ((port_state.control_word & CW_A_MODE) != '0)
                            r.status = STATUS_A_MODE_ERR;
                        else if ((port_state.control_word & CW_A_INPUT) == '0)
                            port_state.latch_a = w.write_data;
                    ADDR_PORT_B:
                        if ((port_state.control_word & CW_B_INPUT) == '0)
                            port_state.latch_b = w.write_data;
                    ADDR_PORT_C:
                        load_port_c(w.write_data);
                    default:
                        if ((w.write_data & CW_MODE_SET) != '0)
                        begin
                            port_state.control_word = w.write_data;
                            port_state.latch_a = '0;
                            port_state.latch_b = '0;
                            port_state.latch_c = '0;
                            r.status = take_port_pins(w.pins_a, w.pins_b, w.pins_c, 1'b1);
                        end
                        else
                        begin
                            bit_sel = 8'd1 << w.write_data[3:1];
                            c_value = port_state.latch_c & ~bit_sel;
                            if (w.write_data[0])
                                c_value = c_value | bit_sel;
                            load_port_c(c_value);
                        end
                endcase
            OP_SAMPLE:
                r.status = take_port_pins(w.pins_a, w.pins_b, w.pins_c, 1'b0);
            default:
                ;
        endcase
        r.drive_a = port_state.latch_a;
        r.drive_b = port_state.latch_b;
        r.drive_c = port_state.latch_c;
        r.drive_mask[0] = (port_state.control_word & CW_A_INPUT) == '0;
        r.drive_mask[1] = (port_state.control_word & CW_B_INPUT) == '0;
        r.drive_mask[2] = (port_state.control_word & CW_CU_INPUT) == '0;
        r.drive_mask[3] = (port_state.control_word & CW_CL_INPUT) == '0;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %02h actual %02h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ppi_item_t   word;
        ppi_result_t want;
        if (!rst_n)
        begin
            port_state = '0;
            expected_words.delete();
            fail_count = 0;
            words_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t ns: result word with none expected, read_data %02h",
                             $time, read_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("drive_a", want.drive_a, drive_a);
                    check_field("drive_b", want.drive_b, drive_b);
                    check_field("drive_c", want.drive_c, drive_c);
                    check_field("drive_mask", {4'd0, want.drive_mask}, {4'd0, drive_mask});
                    check_field("status", {7'd0, want.status}, {7'd0, status});
                end
            end
            if (in_valid && !in_stall)
            begin
                word.operation = operation;
                word.reg_address = reg_address;
                word.write_data = write_data;
                word.pins_a = pins_a;
                word.pins_b = pins_b;
                word.pins_c = pins_c;
                expected_words.insert(expected_words.size(), apply_port_word(word));
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// Top of the mode 0 parallel port interface testbench: clock, reset, word stimulus with
// random idling on both channels, and the final verdict.
// Depends on ppi_pkg, parallel_port_interface_mode0 and ppi_word_checker.

module tb_top
    import ppi_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] OP_NONE = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] operation = OP_READ;
    logic [1:0] reg_address = ADDR_PORT_A;
    logic [7:0] write_data = '0;
    logic [7:0] pins_a = '0;
    logic [7:0] pins_b = '0;
    logic [7:0] pins_c = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] read_data;
    logic [7:0] drive_a;
    logic [7:0] drive_b;
    logic [7:0] drive_c;
    logic [3:0] drive_mask;
    logic       status;

    int fail_count;
    int words_pending;
    int cycle_count = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;

    always #5 clk = ~clk;

    parallel_port_interface_mode0 DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .reg_address(reg_address),
        .write_data(write_data),
        .pins_a(pins_a),
        .pins_b(pins_b),
        .pins_c(pins_c),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .drive_a(drive_a),
        .drive_b(drive_b),
        .drive_c(drive_c),
        .drive_mask(drive_mask),
        .status(status)
    );

    ppi_word_checker checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .reg_address(reg_address),
        .write_data(write_data),
        .pins_a(pins_a),
        .pins_b(pins_b),
        .pins_c(pins_c),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .drive_a(drive_a),
        .drive_b(drive_b),
        .drive_c(drive_c),
        .drive_mask(drive_mask),
        .status(status),
        .fail_count(fail_count),
        .words_pending(words_pending)
    );

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 16) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [1:0] addr,
                             input logic [7:0] data, input logic [7:0] pa,
                             input logic [7:0] pb, input logic [7:0] pc);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        reg_address <= addr;
        write_data <= data;
        pins_a <= pa;
        pins_b <= pb;
        pins_c <= pc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    task automatic send_mode_word();
        logic [7:0] cw;
        cw = 8'($urandom_range(0, 255));
        cw = cw | CW_MODE_SET;
        if ($urandom_range(0, 9) < 7)
            cw = cw & ~CW_A_MODE;
        send_word(OP_WRITE, ADDR_CONTROL, cw, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_word();
        int         pick;
        logic [1:0] op;
        logic [1:0] addr;
        logic [7:0] data;
        pick = $urandom_range(0, 99);
        addr = 2'($urandom_range(0, 3));
        data = 8'($urandom_range(0, 255));
        if (pick < 30)
            op = OP_READ;
        else if (pick < 62)
            op = OP_WRITE;
        else if (pick < 97)
            op = OP_SAMPLE;
        else
            op = OP_NONE;
        if (op == OP_WRITE && addr == ADDR_CONTROL && $urandom_range(0, 3) != 0)
            data = data & ~CW_MODE_SET;
        send_word(op, addr, data, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int sent;
        int run_len;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_READ, ADDR_PORT_A, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_READ, ADDR_PORT_B, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_word(OP_READ, ADDR_PORT_C, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_READ, ADDR_CONTROL, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_word(OP_WRITE, ADDR_PORT_A, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_word(OP_WRITE, ADDR_PORT_B, 8'hA5, 8'h00, 8'h00, 8'h00);
        send_word(OP_WRITE, ADDR_PORT_C, 8'h3C, 8'h00, 8'h00, 8'h00);
        send_word(OP_WRITE, ADDR_CONTROL, 8'h0F, 8'h00, 8'h00, 8'h00);
        send_word(OP_WRITE, ADDR_CONTROL, 8'h70, 8'h00, 8'h00, 8'h00);
        send_word(OP_READ, ADDR_PORT_C, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_NONE, ADDR_CONTROL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_WRITE, ADDR_CONTROL, 8'h9B, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_SAMPLE, ADDR_PORT_A, 8'h00, 8'h5A, 8'hA5, 8'h3C);
        send_word(OP_WRITE, ADDR_PORT_A, 8'h55, 8'h00, 8'h00, 8'h00);
        send_word(OP_WRITE, ADDR_PORT_C, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_word(OP_WRITE, ADDR_CONTROL, 8'h88, 8'hFF, 8'hFF, 8'hF0);
        send_word(OP_WRITE, ADDR_PORT_C, 8'h0F, 8'h00, 8'h00, 8'h00);
        send_word(OP_WRITE, ADDR_CONTROL, 8'hA0, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_WRITE, ADDR_PORT_A, 8'h11, 8'h00, 8'h00, 8'h00);
        send_word(OP_SAMPLE, ADDR_PORT_A, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_WRITE, ADDR_CONTROL, 8'hC0, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_SAMPLE, ADDR_PORT_A, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_WRITE, ADDR_CONTROL, 8'hF0, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_WRITE, ADDR_CONTROL, 8'h86, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_SAMPLE, ADDR_PORT_B, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_WRITE, ADDR_CONTROL, 8'h84, 8'h00, 8'h00, 8'h00);
        send_word(OP_WRITE, ADDR_PORT_B, 8'h77, 8'h00, 8'h00, 8'h00);
        send_word(OP_READ, ADDR_CONTROL, 8'h00, 8'h00, 8'h00, 8'h00);
        drain_words();

        sent = 0;
        while (sent < 520)
        begin
            if (sent >= 440)
                idle_on <= 1'b0;
            send_mode_word();
            sent++;
            run_len = $urandom_range(4, 20);
            repeat (run_len)
            begin
                send_random_word();
                sent++;
            end
            if (sent >= 250 && sent < 275)
                drain_words();
        end

        drain_words();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ppi_pkg.sv
rtl/core/ppi_exec.sv
rtl/core/parallel_port_interface_mode0.sv
tb/ppi_word_checker.sv
tb/tb_top.sv
